// File: design/dhb_pkg.sv
// Shared types, constants and helpers for the dominant hue bucket block.
// No dependencies; every other design file imports this package.
`default_nettype none

package dhb_pkg;

    localparam int NUM_BUCKETS    = 16;
    localparam int COUNT_WIDTH    = 20;
    localparam int HUE_WIDTH      = 8;
    localparam int BRIGHT_WIDTH   = 8;
    localparam int HUE_PER_BUCKET = 16;
    localparam int BKT_W          = $clog2(NUM_BUCKETS);
    localparam int OUT_COUNT_W    = 20;
    localparam int OUT_COUNT_MAX  = (1 << OUT_COUNT_W) - 1;
    localparam int SAT_W          = 33;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [BKT_W-1:0]       LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    // Access to the counter bank: one address, read and optional write.
    typedef struct packed {
        logic [BKT_W-1:0]       idx;
        logic                   wr_en;
        logic [COUNT_WIDTH-1:0] wr_data;
    } t_hist_req;

    // Clamps a counter value to the width of the output count field.
    function automatic logic [OUT_COUNT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] c);
        logic [SAT_W-1:0] w;
        w = SAT_W'(c);
        if (w > SAT_W'(OUT_COUNT_MAX)) begin
            w = SAT_W'(OUT_COUNT_MAX);
        end
        return OUT_COUNT_W'(w);
    endfunction

endpackage

`default_nettype wire

// File: design/dhb_hist.sv
// Bank of hue bucket counters with a single read/write address.
// Depends on dhb_pkg for widths and the request struct.
`default_nettype none

module dhb_hist
    import dhb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_hist_req              i_req,
    output logic [COUNT_WIDTH-1:0]      o_rd_count
);

    logic [COUNT_WIDTH-1:0] r_count [NUM_BUCKETS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_req.wr_en) begin
            r_count[i_req.idx] <= i_req.wr_data;
        end
    end

    assign o_rd_count = r_count[i_req.idx];

endmodule

`default_nettype wire

// File: design/dhb_ctrl.sv
// Sequencer and shared increment/compare unit: counts pixels, scans the
// buckets on the last pixel and holds the result word. Depends on dhb_pkg.
`default_nettype none

module dhb_ctrl
    import dhb_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_pix_valid,
    output logic                         o_pix_ready,
    input  wire logic [HUE_WIDTH-1:0]    i_hue,
    input  wire logic [BRIGHT_WIDTH-1:0] i_brightness,
    input  wire logic                    i_last,
    input  wire logic [BRIGHT_WIDTH-1:0] i_min_value,
    output t_hist_req                    o_req,
    input  wire logic [COUNT_WIDTH-1:0]  i_rd_count,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output logic [BKT_W-1:0]             o_res_bucket,
    output logic [OUT_COUNT_W-1:0]       o_res_count
);

    t_state                 r_state, n_state;
    logic [BKT_W-1:0]       r_idx;
    logic [COUNT_WIDTH-1:0] r_best_cnt;
    logic [BKT_W-1:0]       r_best_idx;
    logic                   r_out_valid;
    logic [BKT_W-1:0]       r_out_bucket;
    logic [OUT_COUNT_W-1:0] r_out_count;

    logic                   pix_acc;
    logic                   scan_last;
    logic                   load_out;
    logic [COUNT_WIDTH-1:0] alu_inc;
    logic                   alu_gt;

    // The one arithmetic unit: saturating increment while counting,
    // greater-than against the running best while scanning.
    assign alu_inc = (i_rd_count == CNT_MAX) ? i_rd_count : i_rd_count + 1'b1;
    assign alu_gt  = i_rd_count > r_best_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pix_valid && i_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_BKT) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pix_ready   = 1'b0;
        o_req.idx     = r_idx;
        o_req.wr_en   = 1'b0;
        o_req.wr_data = '0;
        scan_last     = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pix_ready   = 1'b1;
                o_req.idx     = BKT_W'(i_hue / HUE_PER_BUCKET);
                o_req.wr_en   = i_pix_valid && (i_brightness > i_min_value);
                o_req.wr_data = alu_inc;
            end
            ST_SCAN: begin
                // Each bucket is cleared as it is read.
                o_req.wr_en = 1'b1;
                scan_last   = r_idx == LAST_BKT;
            end
            ST_WAIT: begin
                load_out = !r_out_valid || i_res_ready;
            end
            default: ;
        endcase
    end

    assign pix_acc = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_idx <= scan_last ? '0 : r_idx + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc && i_last) begin
            r_best_cnt <= '0;
            r_best_idx <= '0;
        end else if (r_state == ST_SCAN && alu_gt) begin
            r_best_cnt <= i_rd_count;
            r_best_idx <= r_idx;
        end
        if (load_out) begin
            r_out_bucket <= r_best_idx;
            r_out_count  <= sat_out(r_best_cnt);
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_bucket = r_out_bucket;
    assign o_res_count  = r_out_count;

`ifndef NO_ASSERTIONS
    a_idx_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> (r_idx == '0))
        else $error("scan index not at zero outside the scan");

    a_last_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && i_last) |=> (r_state == ST_SCAN))
        else $error("last pixel did not start a scan");

    a_result_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_WAIT))
        else $error("result word raised outside the wait step");

    a_scan_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (o_req.wr_en && o_req.wr_data == '0 && !o_pix_ready))
        else $error("scan step must clear its bucket and hold off pixels");
`endif

endmodule

`default_nettype wire

// File: design/dominant_hue_bucket.sv
// Hue histogram argmax. A pixel without tlast is accepted and, if its brightness exceeds
// min_value, counted in its bucket in the same cycle; such pixels stream at one per cycle
// while the block is idle. A pixel with tlast is accepted and counted the same way, then a
// scan reads and clears one bucket per cycle through the shared comparator, then a wait step
// loads the result register, which stretches while an earlier result word is not yet taken.
// Synchronous active-low reset clears all counters and any pending result word,
// and sets min_value to 1.
`default_nettype none

module dominant_hue_bucket
    import dhb_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [BRIGHT_WIDTH-1:0] i_cfg_wdata,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [15:0]             s_axis_tdata,  // [7:0] hue, [15:8] brightness
    input  wire logic                    s_axis_tlast,  // last_pixel
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [23:0]                  m_axis_tdata   // [3:0] dominant_bucket,
                                                        // [23:4] dominant_count
);

    logic [BRIGHT_WIDTH-1:0] r_min_value;
    t_hist_req               hist_req;
    logic [COUNT_WIDTH-1:0]  rd_count;
    logic [BKT_W-1:0]        res_bucket;
    logic [OUT_COUNT_W-1:0]  res_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value <= BRIGHT_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_min_value <= i_cfg_wdata;
        end
    end

    dhb_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (hist_req),
        .o_rd_count (rd_count)
    );

    dhb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (s_axis_tvalid),
        .o_pix_ready  (s_axis_tready),
        .i_hue        (s_axis_tdata[7:0]),
        .i_brightness (s_axis_tdata[15:8]),
        .i_last       (s_axis_tlast),
        .i_min_value  (r_min_value),
        .o_req        (hist_req),
        .i_rd_count   (rd_count),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_bucket (res_bucket),
        .o_res_count  (res_count)
    );

    assign m_axis_tdata = {res_count, res_bucket};

endmodule

`default_nettype wire
